// ----- rtl/mmn_pkg.sv -----
// Shared types and constants for the magnetometer min/max normalizer.
`timescale 1ns / 1ps
`default_nettype none
package mmn_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 12;
	localparam int NORM_BITS       = 16;
	localparam int FLAG_BITS       = 3;
	localparam int AXES            = 3;
	localparam int CFG_IDX_BITS    = 3;
	localparam logic [NORM_BITS-1:0] OUT_MAX = 16'h7fff;
	localparam logic [NORM_BITS-1:0] OUT_MIN = 16'h8000;

	localparam logic [CFG_IDX_BITS-1:0] REG_TRACKING_ON = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_MID_X = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_MID_Y = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_MID_Z = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_SPAN_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_SPAN_Y = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_SPAN_Z = 3'd6;

	localparam logic FUNC_NORMALIZE = 1'b0;
	localparam logic FUNC_CLEAR     = 1'b1;

	typedef enum logic [1:0] {L_IDLE, L_PREP, L_DIV, L_FIN} lane_state_t;
	typedef enum logic [1:0] {T_IDLE, T_BUSY, T_HOLD} top_state_t;
endpackage
`default_nettype wire

// ----- rtl/mmn_lane.sv -----
// One axis: range tracking, bit-serial divide, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module mmn_lane #(
	parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mmn_pkg::FRAC_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire                             clear,
	input  wire                             tracking_on,
	input  wire  [SAMPLE_BITS-1:0]          sample,
	input  wire  [SAMPLE_BITS:0]            fixed_mid,
	input  wire  [SAMPLE_BITS-1:0]          fixed_span,
	output logic                            done,
	output logic [mmn_pkg::NORM_BITS-1:0]   norm,
	output logic                            zero_flag,
	output logic                            sat_flag
);
	localparam int SB = SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int AW = SB + 2;
	localparam int MW = SB + 3;
	localparam int NW = SB + FRAC_BITS + 3;
	localparam int CW = $clog2(NW);
	localparam int NB = mmn_pkg::NORM_BITS;

	mmn_pkg::lane_state_t state_q, state_d;
	logic signed [SB-1:0] hi_q, lo_q, s_q;
	logic                 clr_q, trk_q, neg_q;
	logic [DW-1:0]        d_q, rem_q;
	logic [NW-1:0]        nsh_q, quo_q;
	logic [CW-1:0]        cnt_q;

	logic [SB:0]   mid_trk, span_trk;
	logic [MW-1:0] m_ext, s2_ext, diff, mag;
	logic [DW-1:0] d_sel;
	logic [NW-1:0] num;
	logic [DW:0]   trial;
	logic          ge, over;

	always_comb begin
		mid_trk  = {hi_q[SB-1], hi_q} + {lo_q[SB-1], lo_q};
		span_trk = {hi_q[SB-1], hi_q} - {lo_q[SB-1], lo_q};
		m_ext    = trk_q ? {{2{mid_trk[SB]}}, mid_trk} : {{2{fixed_mid[SB]}}, fixed_mid};
		d_sel    = trk_q ? span_trk : {1'b0, fixed_span};
		s2_ext   = {{2{s_q[SB-1]}}, s_q, 1'b0};
		diff     = s2_ext - m_ext;
		mag      = diff[MW-1] ? (MW'(0) - diff) : diff;
		num      = {1'b0, mag[AW-1:0], {FRAC_BITS{1'b0}}}
			+ {{(NW-DW+1){1'b0}}, d_sel[DW-1:1]};
		trial    = {rem_q, nsh_q[NW-1]};
		ge       = trial >= {1'b0, d_q};
		over     = neg_q ? (quo_q > NW'(mmn_pkg::OUT_MIN))
			: (quo_q > NW'(mmn_pkg::OUT_MAX));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmn_pkg::L_IDLE: if (start) state_d = mmn_pkg::L_PREP;
			mmn_pkg::L_PREP: begin
				if (clr_q || d_sel == DW'(0)) state_d = mmn_pkg::L_IDLE;
				else state_d = mmn_pkg::L_DIV;
			end
			mmn_pkg::L_DIV: if (cnt_q == CW'(NW - 1)) state_d = mmn_pkg::L_FIN;
			mmn_pkg::L_FIN: state_d = mmn_pkg::L_IDLE;
			default: state_d = mmn_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmn_pkg::L_IDLE;
			hi_q    <= '0;
			lo_q    <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (state_q == mmn_pkg::L_IDLE && start) begin
				if (clear) begin
					hi_q <= '0;
					lo_q <= '0;
				end else if (tracking_on) begin
					if ($signed(sample) > hi_q) hi_q <= sample;
					else if ($signed(sample) < lo_q) lo_q <= sample;
				end
			end
			if (state_q == mmn_pkg::L_PREP && (clr_q || d_sel == DW'(0))) done <= 1'b1;
			if (state_q == mmn_pkg::L_FIN) done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mmn_pkg::L_IDLE: begin
				s_q   <= sample;
				clr_q <= clear;
				trk_q <= tracking_on;
			end
			mmn_pkg::L_PREP: begin
				norm      <= '0;
				sat_flag  <= 1'b0;
				zero_flag <= !clr_q && d_sel == DW'(0);
				d_q       <= d_sel;
				neg_q     <= diff[MW-1];
				nsh_q     <= num;
				rem_q     <= '0;
				quo_q     <= '0;
				cnt_q     <= '0;
			end
			mmn_pkg::L_DIV: begin
				rem_q <= ge ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], ge};
				nsh_q <= {nsh_q[NW-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
			end
			mmn_pkg::L_FIN: begin
				sat_flag <= over;
				if (over) norm <= neg_q ? mmn_pkg::OUT_MIN : mmn_pkg::OUT_MAX;
				else norm <= neg_q ? (NB'(0) - quo_q[NB-1:0]) : quo_q[NB-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/magnetometer_minmax_normalizer.sv -----
// Top level: stream ports, configuration registers, three axis lanes and the result merge.
// Magnetometer min/max normalizer.
// Input beats on s_axis: tdata holds sample_x/y/z, tuser is func (1 clears the
// tracked ranges and returns an all-zero result). Each beat gives one result
// beat on m_axis: tdata holds norm_x/y/z (Q3.12), tuser the zero-span and
// saturated flags. The three axes run in parallel lanes; each lane updates its
// range at the accepting edge, then prepares the dividend (adding half the
// span for rounding), runs its bit-serial restoring divider and saturates the
// quotient; the merge then loads the output register. On a clear beat, and in
// a lane with a zero span, the divider is skipped; a lane that finishes early
// waits for the others. One beat is in the lanes at a time; s_axis_tready is
// high while the lanes are idle, also while a finished result waits in the
// output register. If m_axis stalls, a second result is held in the lanes
// until the output register frees.
// Reset clears the tracked ranges, sets tracking on and zeroes the fixed
// registers. Configuration writes via cfg_we/cfg_index/cfg_data take effect
// at once; the user must make them only while the block is idle, as the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_minmax_normalizer #(
	parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mmn_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [mmn_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire  [SAMPLE_BITS:0]                 cfg_data,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// sample_x, sample_y, sample_z
	input  wire  [((3*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
	// func
	input  wire                                  s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// norm_x, norm_y, norm_z
	output logic [3*mmn_pkg::NORM_BITS-1:0]      m_axis_tdata,
	// zero_span_flags, saturated_flags
	output logic [2*mmn_pkg::FLAG_BITS-1:0]      m_axis_tuser
);
	localparam int SB = SAMPLE_BITS;
	localparam int NB = mmn_pkg::NORM_BITS;

	logic                tracking_q;
	logic [SB:0]         fmid_q  [mmn_pkg::AXES];
	logic [SB-1:0]       fspan_q [mmn_pkg::AXES];
	mmn_pkg::top_state_t state_q, state_d;
	logic                start;
	logic [mmn_pkg::AXES-1:0] done, zf, sf;
	logic [mmn_pkg::AXES-1:0] done_q;
	logic [NB-1:0]       norm [mmn_pkg::AXES];
	logic                load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b1;
			for (int i = 0; i < mmn_pkg::AXES; i++) begin
				fmid_q[i]  <= '0;
				fspan_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmn_pkg::REG_TRACKING_ON:  tracking_q <= cfg_data[0];
				mmn_pkg::REG_FIXED_MID_X:  fmid_q[0]  <= cfg_data;
				mmn_pkg::REG_FIXED_MID_Y:  fmid_q[1]  <= cfg_data;
				mmn_pkg::REG_FIXED_MID_Z:  fmid_q[2]  <= cfg_data;
				mmn_pkg::REG_FIXED_SPAN_X: fspan_q[0] <= cfg_data[SB-1:0];
				mmn_pkg::REG_FIXED_SPAN_Y: fspan_q[1] <= cfg_data[SB-1:0];
				mmn_pkg::REG_FIXED_SPAN_Z: fspan_q[2] <= cfg_data[SB-1:0];
				default: ;
			endcase
		end
	end

	assign start = s_axis_tvalid && s_axis_tready;

	for (genvar a = 0; a < mmn_pkg::AXES; a++) begin : g_lane
		mmn_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.start      (start),
			.clear      (s_axis_tuser == mmn_pkg::FUNC_CLEAR),
			.tracking_on(tracking_q),
			.sample     (s_axis_tdata[a*SB +: SB]),
			.fixed_mid  (fmid_q[a]),
			.fixed_span (fspan_q[a]),
			.done       (done[a]),
			.norm       (norm[a]),
			.zero_flag  (zf[a]),
			.sat_flag   (sf[a])
		);
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load          = 1'b0;
		unique case (state_q)
			mmn_pkg::T_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = mmn_pkg::T_BUSY;
			end
			mmn_pkg::T_BUSY: begin
				if (&(done_q | done)) begin
					if (!m_axis_tvalid || m_axis_tready) begin
						load    = 1'b1;
						state_d = mmn_pkg::T_IDLE;
					end else begin
						state_d = mmn_pkg::T_HOLD;
					end
				end
			end
			mmn_pkg::T_HOLD: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					load    = 1'b1;
					state_d = mmn_pkg::T_IDLE;
				end
			end
			default: state_d = mmn_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mmn_pkg::T_IDLE;
			m_axis_tvalid <= 1'b0;
			done_q        <= '0;
		end else begin
			state_q <= state_d;
			if (load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			// lanes may finish on different cycles
			if (load) done_q <= '0;
			else done_q <= done_q | done;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata <= {norm[2], norm[1], norm[0]};
			m_axis_tuser <= {sf, zf};
		end
	end
endmodule
`default_nettype wire
